>>> rtl/stl_pkg.sv
// Shared types and constants of the script token lexer.
`default_nettype none
package stl_pkg;

    localparam int STORE_BYTES = 32;
    localparam int TEXT_BITS   = STORE_BYTES * 8;
    localparam int TDATA_BITS  = 360;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_OPEN_STR   = 3'd1;
    localparam logic [2:0] ERR_STR_LONG   = 3'd2;
    localparam logic [2:0] ERR_OPEN_CMT   = 3'd3;
    localparam logic [2:0] ERR_ILLEGAL    = 3'd4;
    localparam logic [2:0] ERR_IDENT_LONG = 3'd5;

    localparam logic [5:0] KIND_LAST = 6'd39;

    typedef struct packed {
        logic [5:0]           kind;
        logic [31:0]          number_value;
        logic [5:0]           text_length;
        logic [TEXT_BITS-1:0] text;
        logic [19:0]          start_offset;
        logic [19:0]          start_line;
        logic [19:0]          start_column;
        logic [2:0]           error_code;
        logic                 last_of_run;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_push;

endpackage
`default_nettype wire

>>> rtl/stl_front.sv
// Lexer front end: classifies each byte and produces up to two results per byte.
`default_nettype none
module stl_front import stl_pkg::*; #(
    parameter int TEXT_CAPACITY = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    output t_push           o_push
);
    localparam logic [5:0] CAP = 6'(TEXT_CAPACITY);

    typedef enum logic [3:0] {
        MD_IDLE, MD_NUMBER, MD_STRING, MD_IDENT, MD_BANG,
        MD_EQ, MD_LT, MD_GT, MD_SLASH, MD_COMMENT
    } t_mode;

    localparam logic [71:0] KW_WORD [16] = '{
        72'("IF"), 72'("IN"), 72'("OR"), 72'("AND"), 72'("SET"), 72'("VAR"),
        72'("DROP"), 72'("ELSE"), 72'("NULL"), 72'("PUSH"), 72'("VOID"),
        72'("PRINT"), 72'("RETURN"), 72'("FOREACH"), 72'({"SET_", "USER"}),
        72'("SCHEDULER")};
    localparam logic [3:0] KW_LEN [16] = '{
        4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd7, 4'd8, 4'd9};
    localparam logic [5:0] KW_KIND [16] = '{
        6'd28, 6'd29, 6'd31, 6'd24, 6'd37, 6'd38, 6'd25, 6'd26, 6'd30,
        6'd33, 6'd39, 6'd32, 6'd35, 6'd27, 6'd34, 6'd36};

    t_mode                r_mode, n_mode;
    logic [TEXT_BITS-1:0] r_text, n_text;
    logic [5:0]           r_dlen, n_dlen, r_rlen, n_rlen;
    logic                 r_esc, n_esc, r_halted, n_halted;
    logic [31:0]          r_acc, n_acc;
    logic [19:0]          r_off, n_off, r_line, n_line, r_col, n_col;
    logic [19:0]          r_ts_off, n_ts_off, r_ts_line, n_ts_line, r_ts_col, n_ts_col;
    t_res                 n_res [2];
    logic [1:0]           n_cnt;
    logic                 n_go_idle;
    logic [5:0]           n_kw;
    logic [5:0]           n_single;

    function automatic logic [19:0] sat_inc(input logic [19:0] v);
        return (v == '1) ? v : v + 20'd1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [TEXT_BITS-1:0] mask_text(input logic [TEXT_BITS-1:0] t,
                                                        input logic [5:0] len);
        logic [TEXT_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < STORE_BYTES; i++) begin
            if (6'(i) < len) begin
                m[i*8 +: 8] = t[i*8 +: 8];
            end
        end
        return m;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [TEXT_BITS-1:0] t,
                                           input logic [5:0] len);
        logic [5:0] k;
        logic       hit;
        k = '0;
        for (int w = 0; w < 16; w++) begin
            hit = (len == {2'b00, KW_LEN[w]});
            for (int i = 0; i < 9; i++) begin
                if (i < int'(KW_LEN[w])) begin
                    if (t[i*8 +: 8] != KW_WORD[w][(int'(KW_LEN[w]) - 1 - i)*8 +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                k = KW_KIND[w];
            end
        end
        return k;
    endfunction

    function automatic t_res mk(input logic [5:0] kind, input logic [31:0] num,
                                input logic [5:0] tlen, input logic [TEXT_BITS-1:0] t,
                                input logic [19:0] off, input logic [19:0] line,
                                input logic [19:0] col, input logic [2:0] err);
        t_res r;
        r.kind         = kind;
        r.number_value = num;
        r.text_length  = tlen;
        r.text         = mask_text(t, tlen);
        r.start_offset = off;
        r.start_line   = line;
        r.start_column = col;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    always_comb begin
        n_mode = r_mode; n_text = r_text; n_dlen = r_dlen; n_rlen = r_rlen;
        n_esc = r_esc; n_halted = r_halted; n_acc = r_acc;
        n_off = r_off; n_line = r_line; n_col = r_col;
        n_ts_off = r_ts_off; n_ts_line = r_ts_line; n_ts_col = r_ts_col;
        n_res[0] = '0; n_res[1] = '0; n_cnt = '0; n_go_idle = 1'b0;
        n_kw = '0; n_single = '0;
        if (!r_halted) begin
            unique case (r_mode)
                MD_NUMBER: begin
                    if (is_digit(i_byte)) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {24'd0, i_byte - 8'd48};
                        n_off = sat_inc(n_off);
                        n_col = sat_inc(n_col);
                    end else begin
                        n_mode = MD_IDLE;
                        n_res[0] = mk(6'd1, r_acc, 6'd0, n_text, r_ts_off, r_ts_line,
                                      r_ts_col, ERR_NONE);
                        n_cnt = 2'd1;
                        n_go_idle = 1'b1;
                    end
                end
                MD_IDENT: begin
                    if (is_letter(i_byte) || is_digit(i_byte)) begin
                        if (r_rlen < CAP) begin
                            n_text[r_rlen[4:0]*8 +: 8] = i_byte;
                            n_dlen = r_rlen + 6'd1;
                            n_rlen = r_rlen + 6'd1;
                        end else begin
                            n_dlen = r_rlen;
                        end
                        n_off = sat_inc(n_off);
                        n_col = sat_inc(n_col);
                    end else begin
                        n_mode = MD_IDLE;
                        if (r_rlen >= CAP) begin
                            n_res[0] = mk(6'd0, 32'd0, 6'd0, n_text, r_off, r_line, r_col,
                                          ERR_IDENT_LONG);
                            n_halted = 1'b1;
                        end else begin
                            n_kw = kw_kind(r_text, r_rlen);
                            if (n_kw != 6'd0) begin
                                n_res[0] = mk(n_kw, 32'd0, 6'd0, n_text, r_ts_off,
                                              r_ts_line, r_ts_col, ERR_NONE);
                            end else begin
                                n_res[0] = mk(6'd3, 32'd0, r_rlen, n_text, r_ts_off,
                                              r_ts_line, r_ts_col, ERR_NONE);
                            end
                        end
                        n_cnt = 2'd1;
                        n_go_idle = 1'b1;
                    end
                end
                MD_STRING: begin
                    if (i_byte == 8'd0 || i_byte == 8'd10 || i_byte == 8'd13) begin
                        n_res[0] = mk(6'd0, 32'd0, 6'd0, n_text, r_off, r_line, r_col,
                                      ERR_OPEN_STR);
                        n_cnt = 2'd1;
                        n_halted = 1'b1;
                        n_mode = MD_IDLE;
                    end else if (i_byte == "\"") begin
                        n_off = sat_inc(n_off);
                        n_col = sat_inc(n_col);
                        n_mode = MD_IDLE;
                        if (r_rlen >= CAP) begin
                            n_res[0] = mk(6'd0, 32'd0, 6'd0, n_text, n_off, n_line, n_col,
                                          ERR_STR_LONG);
                            n_halted = 1'b1;
                        end else begin
                            if (r_esc && n_dlen < CAP) begin
                                n_text[n_dlen[4:0]*8 +: 8] = "\\";
                                n_dlen = n_dlen + 6'd1;
                            end
                            n_esc = 1'b0;
                            n_res[0] = mk(6'd2, 32'd0, n_dlen, n_text, r_ts_off, r_ts_line,
                                          r_ts_col, ERR_NONE);
                        end
                        n_cnt = 2'd1;
                    end else begin
                        if (r_rlen < CAP) begin
                            n_rlen = r_rlen + 6'd1;
                        end
                        if (r_esc) begin
                            n_esc = 1'b0;
                            if (i_byte != "\\" && i_byte != "n" && i_byte != "r" &&
                                i_byte != "t") begin
                                if (n_dlen < CAP) begin
                                    n_text[n_dlen[4:0]*8 +: 8] = "\\";
                                    n_dlen = n_dlen + 6'd1;
                                end
                            end
                            if (n_dlen < CAP) begin
                                case (i_byte)
                                    "n":     n_text[n_dlen[4:0]*8 +: 8] = 8'd10;
                                    "r":     n_text[n_dlen[4:0]*8 +: 8] = 8'd13;
                                    "t":     n_text[n_dlen[4:0]*8 +: 8] = 8'd9;
                                    default: n_text[n_dlen[4:0]*8 +: 8] = i_byte;
                                endcase
                                n_dlen = n_dlen + 6'd1;
                            end
                        end else if (i_byte == "\\") begin
                            n_esc = 1'b1;
                        end else if (n_dlen < CAP) begin
                            n_text[n_dlen[4:0]*8 +: 8] = i_byte;
                            n_dlen = n_dlen + 6'd1;
                        end
                        n_off = sat_inc(n_off);
                        n_col = sat_inc(n_col);
                    end
                end
                MD_COMMENT: begin
                    if (i_byte == 8'd0) begin
                        n_res[0] = mk(6'd0, 32'd0, 6'd0, n_text, r_ts_off, r_line, r_col,
                                      ERR_OPEN_CMT);
                        n_cnt = 2'd1;
                        n_halted = 1'b1;
                        n_mode = MD_IDLE;
                    end else begin
                        n_off = sat_inc(n_off);
                        if (i_byte == 8'd10) begin
                            n_line = sat_inc(n_line);
                            n_col = '0;
                        end else begin
                            n_col = sat_inc(n_col);
                        end
                        if (r_esc && i_byte == "/") begin
                            n_esc = 1'b0;
                            n_mode = MD_IDLE;
                        end else begin
                            n_esc = (i_byte == "*");
                        end
                    end
                end
                MD_BANG, MD_EQ, MD_LT, MD_GT: begin
                    n_mode = MD_IDLE;
                    unique case (r_mode)
                        MD_BANG: n_kw = 6'd4;
                        MD_EQ:   n_kw = 6'd5;
                        MD_LT:   n_kw = 6'd8;
                        default: n_kw = 6'd10;
                    endcase
                    if (i_byte == "=") begin
                        n_kw = (r_mode == MD_EQ) ? 6'd6 : (n_kw == 6'd4) ? 6'd7 : n_kw + 6'd1;
                        n_off = sat_inc(n_off);
                        n_col = sat_inc(n_col);
                    end else begin
                        n_go_idle = 1'b1;
                    end
                    n_res[0] = mk(n_kw, 32'd0, 6'd0, n_text, r_ts_off, r_ts_line, r_ts_col,
                                  ERR_NONE);
                    n_cnt = 2'd1;
                end
                MD_SLASH: begin
                    if (i_byte == "*") begin
                        n_ts_off = r_off;
                        n_esc = 1'b0;
                        n_mode = MD_COMMENT;
                        n_off = sat_inc(n_off);
                        n_col = sat_inc(n_col);
                    end else begin
                        n_mode = MD_IDLE;
                        n_res[0] = mk(6'd15, 32'd0, 6'd0, n_text, r_ts_off, r_ts_line,
                                      r_ts_col, ERR_NONE);
                        n_cnt = 2'd1;
                        n_go_idle = 1'b1;
                    end
                end
                default: begin
                    n_go_idle = 1'b1;
                end
            endcase

            if (n_go_idle && !n_halted) begin
                n_mode = MD_IDLE;
                if (i_byte == 8'd0) begin
                    n_res[n_cnt[0]] = mk(6'd0, 32'd0, 6'd0, n_text, n_off, n_line, n_col,
                                         ERR_NONE);
                    n_ts_off = n_off; n_ts_line = n_line; n_ts_col = n_col;
                    n_cnt = n_cnt + 2'd1;
                    n_off = '0; n_line = '0; n_col = '0;
                end else if (i_byte == " " || i_byte == 8'd9 || i_byte == 8'd10 ||
                             i_byte == 8'd13) begin
                    n_off = sat_inc(n_off);
                    if (i_byte == 8'd10) begin
                        n_line = sat_inc(n_line);
                        n_col = '0;
                    end else begin
                        n_col = sat_inc(n_col);
                    end
                end else begin
                    n_ts_off = n_off; n_ts_line = n_line; n_ts_col = n_col;
                    case (i_byte)
                        "+": n_single = 6'd12;
                        "-": n_single = 6'd13;
                        "*": n_single = 6'd14;
                        "%": n_single = 6'd16;
                        ".": n_single = 6'd17;
                        ",": n_single = 6'd18;
                        ";": n_single = 6'd19;
                        "(": n_single = 6'd20;
                        ")": n_single = 6'd21;
                        "{": n_single = 6'd22;
                        "}": n_single = 6'd23;
                        default: n_single = 6'd0;
                    endcase
                    if (is_digit(i_byte)) begin
                        n_acc = {24'd0, i_byte - 8'd48};
                        n_mode = MD_NUMBER;
                    end else if (i_byte == "\"") begin
                        n_rlen = '0; n_dlen = '0; n_esc = 1'b0;
                        n_mode = MD_STRING;
                    end else if (is_letter(i_byte)) begin
                        n_text[7:0] = i_byte;
                        n_dlen = 6'd1; n_rlen = 6'd1;
                        n_mode = MD_IDENT;
                    end else if (i_byte == "!") begin
                        n_mode = MD_BANG;
                    end else if (i_byte == "=") begin
                        n_mode = MD_EQ;
                    end else if (i_byte == "<") begin
                        n_mode = MD_LT;
                    end else if (i_byte == ">") begin
                        n_mode = MD_GT;
                    end else if (i_byte == "/") begin
                        n_mode = MD_SLASH;
                    end else if (n_single != 6'd0) begin
                        n_res[n_cnt[0]] = mk(n_single, 32'd0, 6'd0, n_text, n_ts_off,
                                             n_ts_line, n_ts_col, ERR_NONE);
                        n_cnt = n_cnt + 2'd1;
                    end else begin
                        n_res[n_cnt[0]] = mk(6'd0, 32'd0, 6'd0, n_text, sat_inc(n_off),
                                             n_line, n_col, ERR_ILLEGAL);
                        n_cnt = n_cnt + 2'd1;
                        n_halted = 1'b1;
                    end
                    if (!n_halted) begin
                        n_off = sat_inc(n_off);
                        n_col = sat_inc(n_col);
                    end
                end
            end
            if (n_cnt == 2'd2) begin
                n_res[1].last_of_run = 1'b1;
            end else if (n_cnt == 2'd1) begin
                n_res[0].last_of_run = 1'b1;
            end
        end
    end

    always_comb begin
        o_push.count = i_take ? n_cnt : 2'd0;
        o_push.res0  = n_res[0];
        o_push.res1  = n_res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MD_IDLE; r_dlen <= '0; r_rlen <= '0; r_esc <= 1'b0;
            r_halted <= 1'b0; r_acc <= '0; r_off <= '0; r_line <= '0; r_col <= '0;
            r_ts_off <= '0; r_ts_line <= '0; r_ts_col <= '0;
        end else if (i_take) begin
            r_mode <= n_mode; r_dlen <= n_dlen; r_rlen <= n_rlen; r_esc <= n_esc;
            r_halted <= n_halted; r_acc <= n_acc; r_off <= n_off; r_line <= n_line;
            r_col <= n_col; r_ts_off <= n_ts_off; r_ts_line <= n_ts_line;
            r_ts_col <= n_ts_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_text <= n_text;
        end
    end
endmodule
`default_nettype wire

>>> rtl/stl_queue.sv
// Four-entry result queue that takes up to two results and gives one per cycle when popped.
`default_nettype none
module stl_queue import stl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_push     i_push,
    input  wire logic i_pop,
    output logic      o_room,
    output logic      o_valid,
    output t_res      o_head
);
    t_res       r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;

    assign o_room  = r_count <= 3'd2;
    assign o_valid = r_count != 3'd0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= r_wr + i_push.count;
            r_rd <= r_rd + {1'b0, i_pop};
            r_count <= r_count + {1'b0, i_push.count} - {2'b00, i_pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/stl_back.sv
// Output stage: holds one result at a time on the master-side stream.
`default_nettype none
module stl_back import stl_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  t_res                       i_q_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [TDATA_BITS-1:0]      o_tdata,
    output logic [5:0]                 o_tuser,
    output logic                       o_tlast
);
    logic r_valid;
    t_res r_res;

    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_tuser = r_res.kind;
    assign o_tlast = r_res.last_of_run;
    assign o_tdata = {3'd0, r_res.error_code, r_res.start_column, r_res.start_line,
                      r_res.start_offset, r_res.text, r_res.text_length,
                      r_res.number_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_q_head;
        end
    end
endmodule
`default_nettype wire

>>> rtl/script_token_lexer.sv
// Top level of the script token lexer.
// The lexer takes one source byte per cycle while the queue has room and emits tokens and
// errors on the master stream, one transaction per cycle while the receiver is ready. A byte
// that completes one token and starts or causes another yields two transactions; a
// four-entry queue between the lexer and the output register absorbs them, and input is
// taken whenever the queue has two free entries, so sustained input runs at one byte per
// cycle while results keep pace. Each result passes through the queue and then the output
// register. After an error the lexer drops all input until reset.
`default_nettype none
module script_token_lexer import stl_pkg::*; #(
    parameter int TEXT_CAPACITY = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [7:0]            i_s_axis_tdata,  // text_byte
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // number_value, text_length, text_word_0..3, start_offset, start_line,
    // start_column, error_code
    output logic [TDATA_BITS-1:0]      o_m_axis_tdata,
    output logic [5:0]                 o_m_axis_tuser,  // kind
    output logic                       o_m_axis_tlast   // last_of_run
);
    t_push push;
    t_res  head;
    logic  room, q_valid, pop, take;

    assign o_s_axis_tready = room;
    assign take = i_s_axis_tvalid && room;

    stl_front #(.TEXT_CAPACITY(TEXT_CAPACITY)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_byte(i_s_axis_tdata), .o_push(push));

    stl_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_pop(pop),
        .o_room(room), .o_valid(q_valid), .o_head(head));

    stl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_head(head),
        .o_pop(pop), .o_valid(o_m_axis_tvalid), .i_ready(i_m_axis_tready),
        .o_tdata(o_m_axis_tdata), .o_tuser(o_m_axis_tuser), .o_tlast(o_m_axis_tlast));
endmodule
`default_nettype wire

>>> rtl/stl_checker.sv
// Port-level checks of the script token lexer and their binding.
`default_nettype none
module stl_checker import stl_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [TDATA_BITS-1:0] o_m_axis_tdata,
    input wire logic [5:0]            o_m_axis_tuser,
    input wire logic                  o_m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled transaction changed");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= KIND_LAST)
        else $error("kind out of range");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[356:354] != ERR_NONE |->
        o_m_axis_tuser == 6'd0 && o_m_axis_tlast && o_m_axis_tdata[37:32] == 6'd0)
        else $error("malformed error transaction");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[37:32] <= 6'd32)
        else $error("text length out of range");
endmodule

bind script_token_lexer stl_checker u_stl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready), .o_m_axis_tdata(o_m_axis_tdata),
    .o_m_axis_tuser(o_m_axis_tuser), .o_m_axis_tlast(o_m_axis_tlast));
`default_nettype wire
